// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the stack machine execute unit: instruction
// codes, result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package smx_pkg;

  // Instruction codes; the unused code is executed as a nop
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_PRINT = 3'd1,
    OP_PEEK  = 3'd2,
    OP_POP   = 3'd3,
    OP_SWAP  = 3'd4,
    OP_ADD   = 3'd5,
    OP_NOP   = 3'd6
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_SHORT = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SWAP_RD2,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_ADD_RD2,
    ST_ADD_WR,
    ST_PRINT
  } state_e;

endpackage

// ===== rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack instruction per request on a bounded stack of signed
// words held in a single-port synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   Results come out one per cycle, each marked by result_strobe_o for one
//   cycle; last_o flags the final result of a request. The receiver cannot
//   stall, so results are never held back.
// Sequencing (from the accepting edge to the last result strobe):
//   push, pop, nop and every error: result registered at the accepting edge;
//     busy stays low, so a new request may follow in the next cycle.
//   peek: read, show. add: read, read, write. swap: read, read, write, write.
//   print all: top read first, then one entry read and shown per cycle.
// The single memory port sets these steps: one access per cycle.
// Reset clears the entry count and the sequencer; the memory is not
// cleared, as entries are only read below the count.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] push_value_i,
  output logic               result_strobe_o,
  output logic signed [31:0] result_value_o,
  output logic               value_valid_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  import smx_pkg::*;

  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [WORD_WIDTH-1:0] hold_q, hold_d;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_addr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] mem_rdata;

  logic              strobe_q, strobe_d;
  logic [31:0]       value_q, value_d;
  logic              vvalid_q, vvalid_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;

  logic [AddrW-1:0]  top_addr;
  logic [AddrW-1:0]  below_addr;
  logic              is_empty;
  logic              is_short;
  logic              is_full;
  op_e               op;

  // Sign-extend or cut a stack word to the 32-bit result field
  function automatic logic [31:0] to_out(input logic [WORD_WIDTH-1:0] w);
    to_out = 32'(signed'(w));
  endfunction

  smx_stack_ram #(
    .Depth(STACK_DEPTH),
    .Width(WORD_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign op         = op_e'(operation_i);
  assign top_addr   = AddrW'(count_q - CountW'(1));
  assign below_addr = AddrW'(count_q - CountW'(2));
  assign is_empty   = (count_q == '0);
  assign is_short   = (count_q < CountW'(2));
  assign is_full    = (count_q == CountW'(STACK_DEPTH));
  assign busy       = (state_q != ST_IDLE);

  // Sequence memory accesses and build the next result
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    hold_d    = hold_q;
    mem_we    = 1'b0;
    mem_addr  = top_addr;
    mem_wdata = hold_q;
    strobe_d  = 1'b0;
    value_d   = '0;
    vvalid_d  = 1'b0;
    status_d  = STATUS_OK;
    last_d    = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_PUSH: begin
              strobe_d = 1'b1;
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = AddrW'(count_q);
                mem_wdata = WORD_WIDTH'(push_value_i);
                count_d   = count_q + CountW'(1);
              end
            end
            OP_PRINT: begin
              if (is_empty) begin
                strobe_d = 1'b1;
              end else begin
                ptr_d   = top_addr;
                state_d = ST_PRINT;
              end
            end
            OP_PEEK: begin
              if (is_empty) begin
                strobe_d = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                state_d = ST_PEEK;
              end
            end
            OP_POP: begin
              strobe_d = 1'b1;
              if (is_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                count_d = count_q - CountW'(1);
              end
            end
            OP_SWAP: begin
              if (is_short) begin
                strobe_d = 1'b1;
                status_d = STATUS_SHORT;
              end else begin
                state_d = ST_SWAP_RD2;
              end
            end
            OP_ADD: begin
              if (is_short) begin
                strobe_d = 1'b1;
                status_d = STATUS_SHORT;
              end else begin
                state_d = ST_ADD_RD2;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end

      // Top entry arrives: show it
      ST_PEEK: begin
        strobe_d = 1'b1;
        value_d  = to_out(mem_rdata);
        vvalid_d = 1'b1;
        state_d  = ST_IDLE;
      end

      // Hold the top entry, read the one below
      ST_SWAP_RD2: begin
        hold_d   = mem_rdata;
        mem_addr = below_addr;
        state_d  = ST_SWAP_WR1;
      end

      // Write the lower entry on top
      ST_SWAP_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = top_addr;
        mem_wdata = mem_rdata;
        state_d   = ST_SWAP_WR2;
      end

      // Write the old top below and finish
      ST_SWAP_WR2: begin
        mem_we    = 1'b1;
        mem_addr  = below_addr;
        mem_wdata = hold_q;
        strobe_d  = 1'b1;
        state_d   = ST_IDLE;
      end

      // Hold the top entry, read the one below
      ST_ADD_RD2: begin
        hold_d   = mem_rdata;
        mem_addr = below_addr;
        state_d  = ST_ADD_WR;
      end

      // Write the wrapped sum in place of the lower entry and drop the top
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = below_addr;
        mem_wdata = hold_q + mem_rdata;
        count_d   = count_q - CountW'(1);
        strobe_d  = 1'b1;
        state_d   = ST_IDLE;
      end

      // Show one entry per cycle and advance toward the bottom
      ST_PRINT: begin
        strobe_d = 1'b1;
        value_d  = to_out(mem_rdata);
        vvalid_d = 1'b1;
        last_d   = (ptr_q == '0);
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          mem_addr = ptr_q - AddrW'(1);
          ptr_d    = ptr_q - AddrW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    hold_q   <= hold_d;
    value_q  <= value_d;
    vvalid_q <= vvalid_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_value_o  = value_q;
  assign value_valid_o   = vvalid_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/smx_stack_ram.sv =====
// ----------------------------------------------------------------------------
// smx_stack_ram
// Single-port stack memory with registered read. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module smx_stack_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stack_machine_execute_unit. Requests are driven in
// random bursts with random gaps. A monitor keeps its own shadow stack,
// predicts the results of each accepted request and checks every result
// strobe, field by field, against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  localparam int unsigned STACK_DEPTH     = 64;
  localparam int unsigned RANDOM_REQUESTS = 20;
  localparam int unsigned DRAIN_CYCLES    = STACK_DEPTH + 16;
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [2:0]  OP_UNUSED       = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic        valid;
    status_e     status;
    logic        last;
  } stack_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         operation_i = OP_NOP;
  logic signed [31:0] push_value_i = '0;
  logic               result_strobe_o;
  logic signed [31:0] result_value_o;
  logic               value_valid_o;
  logic [1:0]         status_o;
  logic               last_o;

  // Shadow stack and pending predictions
  logic [31:0]   shadow_stack [STACK_DEPTH];
  int unsigned   shadow_depth = 0;
  stack_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stim_level  = 0;
  bit          gaps_enabled = 1'b1;

  stack_machine_execute_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .WORD_WIDTH (32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_strobe_o(result_strobe_o),
    .result_value_o (result_value_o),
    .value_valid_o  (value_valid_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_expected(logic [31:0] value, logic valid, status_e status,
                                       logic last);
    stack_result_t r;
    r.value  = value;
    r.valid  = valid;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Apply one instruction to the shadow stack and queue its results
  function automatic void execute_instruction(logic [2:0] op, logic [31:0] val);
    logic [31:0] held;
    case (op)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          add_expected('0, 1'b0, STATUS_FULL, 1'b1);
        end else begin
          shadow_stack[shadow_depth] = val;
          shadow_depth++;
          add_expected('0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      OP_PRINT: begin
        if (shadow_depth == 0) begin
          add_expected('0, 1'b0, STATUS_OK, 1'b1);
        end else begin
          for (int i = shadow_depth; i > 0; i--)
            add_expected(shadow_stack[i-1], 1'b1, STATUS_OK, i == 1);
        end
      end
      OP_PEEK: begin
        if (shadow_depth == 0)
          add_expected('0, 1'b0, STATUS_EMPTY, 1'b1);
        else
          add_expected(shadow_stack[shadow_depth-1], 1'b1, STATUS_OK, 1'b1);
      end
      OP_POP: begin
        if (shadow_depth == 0) begin
          add_expected('0, 1'b0, STATUS_EMPTY, 1'b1);
        end else begin
          shadow_depth--;
          add_expected('0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      OP_SWAP: begin
        if (shadow_depth < 2) begin
          add_expected('0, 1'b0, STATUS_SHORT, 1'b1);
        end else begin
          held = shadow_stack[shadow_depth-1];
          shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
          shadow_stack[shadow_depth-2] = held;
          add_expected('0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      OP_ADD: begin
        if (shadow_depth < 2) begin
          add_expected('0, 1'b0, STATUS_SHORT, 1'b1);
        end else begin
          shadow_stack[shadow_depth-2] = shadow_stack[shadow_depth-1] +
                                         shadow_stack[shadow_depth-2];
          shadow_depth--;
          add_expected('0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      default: begin
        add_expected('0, 1'b0, STATUS_OK, 1'b1);
      end
    endcase
  endfunction

  // Check each result strobe, then predict the request accepted at this edge
  always @(posedge clk_i) begin : monitor
    stack_result_t got;
    stack_result_t want;
    if (rst_ni) begin
      if (result_strobe_o) begin
        got.value  = result_value_o;
        got.valid  = value_valid_o;
        got.status = status_e'(status_o);
        got.last   = last_o;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: value %h valid %b status %0d last %b",
                     got.value, got.valid, got.status, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"mismatch: expected value %h valid %b status %0d last %b, ",
                        "got value %h valid %b status %0d last %b"},
                       want.value, want.valid, want.status, want.last,
                       got.value, got.valid, got.status, got.last);
          end
        end
      end
      if (start && !busy)
        execute_instruction(operation_i, push_value_i);
    end
  end

  // Drive one request and hold it until accepted; insert a random, possibly empty gap between bursts
  task automatic send_request(input logic [2:0] op, input logic [31:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (!gaps_enabled || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    operation_i  <= op;
    push_value_i <= val;
    do @(posedge clk_i); while (busy);
    burst_left--;
    // Track the depth to steer the stimulus
    case (op)
      OP_PUSH: if (stim_level < STACK_DEPTH) stim_level++;
      OP_POP:  if (stim_level > 0) stim_level--;
      OP_ADD:  if (stim_level >= 2) stim_level--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Hit the empty and short errors on an empty or one-deep stack
  task automatic test_empty_errors();
    send_request(OP_PEEK, 32'h0);
    send_request(OP_POP, 32'h0);
    send_request(OP_SWAP, 32'h0);
    send_request(OP_ADD, 32'h0);
    send_request(OP_PRINT, 32'h0);
    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_SWAP, 32'h0);
    send_request(OP_ADD, 32'h0);
    send_request(OP_PEEK, 32'hdead_beef);
  endtask

  // Check ordering, swap and wrapping add on small stacks
  task automatic test_arith_and_order();
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_SWAP, 32'h0);
    send_request(OP_PRINT, 32'h0);
    send_request(OP_ADD, 32'h0);
    send_request(OP_PUSH, 32'h0000_0001);
    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_ADD, 32'h0);
    send_request(OP_PEEK, 32'h0);
    send_request(OP_NOP, 32'h1234_5678);
    send_request(OP_UNUSED, 32'hffff_ffff);
    send_request(OP_PUSH, 32'h0);
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_SWAP, 32'h0);
    send_request(OP_PRINT, 32'h0);
    send_request(OP_POP, 32'h0);
    send_request(OP_PEEK, 32'h0);
  endtask

  // Fill to capacity back to back, push on full, print all, swap and peek
  task automatic test_full_stack();
    gaps_enabled = 1'b0;
    while (stim_level < STACK_DEPTH)
      send_request(OP_PUSH, pick_value());
    gaps_enabled = 1'b1;
    send_request(OP_PUSH, $urandom());
    send_request(OP_PRINT, 32'h0);
    send_request(OP_SWAP, 32'h0);
    send_request(OP_PEEK, 32'h0);
  endtask

  // Random programs that wander down from a full stack
  task automatic test_random_programs();
    int unsigned pick;
    logic [2:0]  op;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if      (pick < 28) op = OP_PUSH;
      else if (pick < 34) op = OP_PRINT;
      else if (pick < 44) op = OP_PEEK;
      else if (pick < 62) op = OP_POP;
      else if (pick < 72) op = OP_SWAP;
      else if (pick < 86) op = OP_ADD;
      else if (pick < 93) op = OP_NOP;
      else if (pick < 96) op = OP_UNUSED;
      else                op = OP_PUSH;
      if (op == OP_PUSH && stim_level >= STACK_DEPTH - 2) op = OP_POP;
      send_request(op, (op == OP_PUSH) ? pick_value() : $urandom());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_errors();
    test_arith_and_order();
    test_full_stack();
    test_random_programs();
    start <= 1'b0;
    // Drain outstanding results, then allow for a late stray strobe
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
